FILE: hw/rtl/lpwr_pkg.sv
// Shared types and constants for the LED pulse width receiver.
package lpwr_pkg;

	localparam int unsigned TIME_W     = 64;
	localparam int unsigned THR_W      = 16;
	localparam int unsigned STRIP_W    = 13;
	localparam int unsigned CNT_W      = 13;
	localparam int unsigned IDX_W      = 12;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned BIT_POS_W  = 3;
	localparam int unsigned MAX_BYTES  = 4096;
	localparam int unsigned ADDR_W     = $clog2(MAX_BYTES);

	// Queue between front and back; depth must be a power of two.
	localparam int unsigned QDEPTH     = 4;
	localparam int unsigned QPTR_W     = $clog2(QDEPTH);
	localparam int unsigned QCNT_W     = QPTR_W + 1;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned OUT_DATA_W = 24;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - (IDX_W + BYTE_W + 2);

	localparam logic [THR_W-1:0]   ZERO_HIGH_MIN_RST = 16'd200;
	localparam logic [THR_W-1:0]   ZERO_HIGH_MAX_RST = 16'd500;
	localparam logic [THR_W-1:0]   GAP_MIN_RST       = 16'd300;
	localparam logic [THR_W-1:0]   GAP_MAX_RST       = 16'd5000;
	localparam logic [THR_W-1:0]   LATCH_MIN_RST     = 16'd6000;
	localparam logic [STRIP_W-1:0] STRIP_BYTES_RST   = 13'd0;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_BYTE  = 2'd1,
		EV_LATCH = 2'd2
	} event_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO_HIGH_MIN = 3'd0,
		REG_ZERO_HIGH_MAX = 3'd1,
		REG_GAP_MIN       = 3'd2,
		REG_GAP_MAX       = 3'd3,
		REG_LATCH_MIN     = 3'd4,
		REG_STRIP_BYTES   = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0]   zero_high_min;
		logic [THR_W-1:0]   zero_high_max;
		logic [THR_W-1:0]   gap_min;
		logic [THR_W-1:0]   gap_max;
		logic [THR_W-1:0]   latch_min;
		logic [STRIP_W-1:0] strip_bytes;
	} cfg_t;

	// One classified edge as handed from front to back.
	typedef struct packed {
		event_kind_t         kind;
		logic [IDX_W-1:0]    idx;
		logic [BYTE_W-1:0]   val;
		logic                stored;
		logic [ADDR_W-1:0]   addr;
	} op_t;

endpackage

FILE: hw/rtl/lpwr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpwr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hw/rtl/lpwr_front.sv
// Front end: measures pulse widths, decodes bits and assembles bytes.
module lpwr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lpwr_pkg::TIME_W-1:0]   edge_time,
	input  logic                          pin_level,
	input  lpwr_pkg::cfg_t                cfg,
	input  logic                          q_full,
	output logic                          push,
	output lpwr_pkg::op_t                 push_op
);

	logic [lpwr_pkg::TIME_W-1:0]    last_q;
	logic                           pend_q;
	logic [lpwr_pkg::BIT_POS_W-1:0] pos_q;
	logic [lpwr_pkg::BYTE_W-1:0]    shift_q;
	logic [lpwr_pkg::CNT_W-1:0]     cnt_q;

	logic [lpwr_pkg::TIME_W-1:0]    width;
	logic                           hi_nz;
	logic                           gt_zmin, lt_zmax, gt_gmin, lt_gmax, gt_latch;
	logic                           in_gap, pos_last, cnt_nz, stored_c;
	logic [lpwr_pkg::BYTE_W-1:0]    merged;

	assign in_ready = !q_full;
	assign push     = in_valid && in_ready;

	// Width is the wrapping difference; anything above 16 bits beats every threshold.
	assign width    = edge_time - last_q;
	assign hi_nz    = |width[lpwr_pkg::TIME_W-1:lpwr_pkg::THR_W];
	assign gt_zmin  = hi_nz || (width[lpwr_pkg::THR_W-1:0] > cfg.zero_high_min);
	assign lt_zmax  = !hi_nz && (width[lpwr_pkg::THR_W-1:0] < cfg.zero_high_max);
	assign gt_gmin  = hi_nz || (width[lpwr_pkg::THR_W-1:0] > cfg.gap_min);
	assign lt_gmax  = !hi_nz && (width[lpwr_pkg::THR_W-1:0] < cfg.gap_max);
	assign gt_latch = hi_nz || (width[lpwr_pkg::THR_W-1:0] > cfg.latch_min);
	assign in_gap   = gt_gmin && lt_gmax;

	assign merged   = shift_q | (lpwr_pkg::BYTE_W'(pend_q) << (3'd7 - pos_q));
	assign pos_last = (pos_q == 3'd7);
	assign cnt_nz   = (cnt_q != '0);
	assign stored_c = (cnt_q < cfg.strip_bytes) &&
	                  (cnt_q < lpwr_pkg::CNT_W'(lpwr_pkg::MAX_BYTES));

	always_comb begin
		push_op        = '0;
		push_op.kind   = lpwr_pkg::EV_NONE;
		if (pin_level && in_gap && pos_last) begin
			push_op.kind   = lpwr_pkg::EV_BYTE;
			push_op.idx    = cnt_q[lpwr_pkg::IDX_W-1:0];
			push_op.val    = merged;
			push_op.stored = stored_c;
			push_op.addr   = cnt_q[lpwr_pkg::ADDR_W-1:0];
		end else if (pin_level && !in_gap && gt_latch && cnt_nz) begin
			push_op.kind   = lpwr_pkg::EV_LATCH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			pend_q  <= 1'b0;
			pos_q   <= '0;
			shift_q <= '0;
			cnt_q   <= '0;
		end else if (push) begin
			last_q <= edge_time;
			if (!pin_level) begin
				pend_q <= !(gt_zmin && lt_zmax);
			end else if (in_gap) begin
				pos_q <= pos_q + 3'd1;
				if (pos_last) begin
					shift_q <= '0;
					if (cnt_q != '1) begin
						cnt_q <= cnt_q + lpwr_pkg::CNT_W'(1);
					end
				end else begin
					shift_q <= merged;
				end
			end else if (gt_latch && cnt_nz) begin
				shift_q <= '0;
				pos_q   <= '0;
				cnt_q   <= '0;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_byte_restarts_pos: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_op.kind == lpwr_pkg::EV_BYTE |=> pos_q == '0 && shift_q == '0)
		else $error("bit position not restarted after byte");
	a_latch_clears_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		push && push_op.kind == lpwr_pkg::EV_LATCH |-> cnt_q != '0)
		else $error("latch issued with empty byte counter");
`endif

endmodule

FILE: hw/rtl/lpwr_queue.sv
// Short queue of classified edges between front and back.
module lpwr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpwr_pkg::op_t push_op,
	output logic          full,
	input  logic          pop,
	output lpwr_pkg::op_t head,
	output logic          empty
);

	lpwr_pkg::op_t               ent_q [lpwr_pkg::QDEPTH];
	logic [lpwr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [lpwr_pkg::QCNT_W-1:0] cnt_q;

	assign full  = (cnt_q == lpwr_pkg::QCNT_W'(lpwr_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + lpwr_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + lpwr_pkg::QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + lpwr_pkg::QCNT_W'(1);
				2'b01:   cnt_q <= cnt_q - lpwr_pkg::QCNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop) && !(pop && empty))
		else $error("queue overflow or underflow");
`endif

endmodule

FILE: hw/rtl/lpwr_back.sv
// Back end: compares completed bytes with the pixel store and builds results.
module lpwr_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_empty,
	input  lpwr_pkg::op_t               head,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lpwr_pkg::event_kind_t       out_kind,
	output logic [lpwr_pkg::IDX_W-1:0]  out_index,
	output logic [lpwr_pkg::BYTE_W-1:0] out_value,
	output logic                        out_stored,
	output logic                        out_changed
);

	lpwr_pkg::op_t               op_s1;
	logic                        v_s1;
	logic [lpwr_pkg::BYTE_W-1:0] rd_data;
	logic [lpwr_pkg::ADDR_W-1:0] clr_addr_q;
	logic                        clr_busy_q;
	logic                        changed_q;
	logic                        out_v_q;

	logic                        adv, is_byte, do_write, differs, chg_out;
	logic                        mem_we;
	logic [lpwr_pkg::ADDR_W-1:0] mem_waddr;
	logic [lpwr_pkg::BYTE_W-1:0] mem_wdata;

	assign adv     = v_s1 && (!out_v_q || out_ready);
	assign pop     = !clr_busy_q && !q_empty && (!v_s1 || adv);
	assign is_byte = (op_s1.kind == lpwr_pkg::EV_BYTE);

	assign differs     = op_s1.stored && (rd_data != op_s1.val);
	assign chg_out     = changed_q || (is_byte && differs);
	assign do_write    = adv && is_byte && op_s1.stored;

	// Zero the whole store after reset, one entry per cycle, before any word is taken.
	assign mem_we    = clr_busy_q || do_write;
	assign mem_waddr = clr_busy_q ? clr_addr_q : op_s1.addr;
	assign mem_wdata = clr_busy_q ? '0 : op_s1.val;

	lpwr_ram #(
		.WIDTH(lpwr_pkg::BYTE_W),
		.DEPTH(lpwr_pkg::MAX_BYTES)
	) u_store (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (pop),
		.raddr(head.addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			op_s1 <= head;
		end
		if (adv) begin
			out_kind    <= op_s1.kind;
			out_index   <= op_s1.idx;
			out_value   <= op_s1.val;
			out_stored  <= op_s1.stored;
			out_changed <= chg_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			out_v_q    <= 1'b0;
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
			changed_q  <= 1'b1;
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + lpwr_pkg::ADDR_W'(1);
				if (clr_addr_q == '1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (adv) begin
				changed_q <= (op_s1.kind == lpwr_pkg::EV_LATCH) ? 1'b0 : chg_out;
			end
		end
	end

	assign out_valid = out_v_q;

`ifndef NO_ASSERTIONS
	a_idle_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop && !v_s1)
		else $error("word taken while the store is being cleared");
	a_write_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		do_write |-> !clr_busy_q)
		else $error("store write during clearing pass");
	a_latch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1.kind == lpwr_pkg::EV_LATCH |=> !changed_q)
		else $error("changed flag survived a latch");
`endif

endmodule

FILE: hw/rtl/led_pulse_width_receiver_core.sv
// Top level of the LED pulse width receiver: config registers, front, queue, back.
//
//  channel   dir  handshake              payload
//  --------  ---  ---------------------  -------------------------------------------
//  s_*       in   s_tvalid / s_tready    tdata: edge_time[63:0]; tuser: pin_level
//  m_*       out  m_tvalid / m_tready    tdata: byte_index, byte_value, byte_stored,
//                                        colors_changed; tuser: event_kind
//  cfg_*     in   cfg_valid / cfg_ready  cfg_index selects register, cfg_data value
//
//  Throughput is one edge word per cycle while the queue is not full: the front
//  does one 64-bit subtract and five threshold compares per word, the back one
//  pixel store read and write. A result passes the queue write, the store read
//  and the output register before m_tvalid; the four-deep queue, the store
//  read stage and the output register absorb master stalls before s_tready drops.
//  After reset the back writes zeros through all 4096 store entries, one per
//  cycle; the queue takes four words meanwhile, then s_tready holds low.
//  cfg_ready is always high; each write is registered and takes effect in the next cycle.
module led_pulse_width_receiver_core (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [lpwr_pkg::TIME_W-1:0]        s_tdata,   // [63:0] edge_time
	input  logic                               s_tuser,   // [0] pin_level

	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [lpwr_pkg::OUT_DATA_W-1:0]    m_tdata,   // [11:0] byte_index,
	                                                      // [19:12] byte_value,
	                                                      // [20] byte_stored,
	                                                      // [21] colors_changed,
	                                                      // [23:22] zero
	output logic [1:0]                         m_tuser,   // [1:0] event_kind

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lpwr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lpwr_pkg::CFG_DATA_W-1:0]    cfg_data
);

	lpwr_pkg::cfg_t                cfg_q;
	logic                          q_full, q_empty, push, pop;
	lpwr_pkg::op_t                 push_op, head;
	lpwr_pkg::event_kind_t         out_kind;
	logic [lpwr_pkg::IDX_W-1:0]    out_index;
	logic [lpwr_pkg::BYTE_W-1:0]   out_value;
	logic                          out_stored, out_changed;

	// Configuration: take every write; indexes past the list are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero_high_min <= lpwr_pkg::ZERO_HIGH_MIN_RST;
			cfg_q.zero_high_max <= lpwr_pkg::ZERO_HIGH_MAX_RST;
			cfg_q.gap_min       <= lpwr_pkg::GAP_MIN_RST;
			cfg_q.gap_max       <= lpwr_pkg::GAP_MAX_RST;
			cfg_q.latch_min     <= lpwr_pkg::LATCH_MIN_RST;
			cfg_q.strip_bytes   <= lpwr_pkg::STRIP_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lpwr_pkg::REG_ZERO_HIGH_MIN: cfg_q.zero_high_min <= cfg_data;
				lpwr_pkg::REG_ZERO_HIGH_MAX: cfg_q.zero_high_max <= cfg_data;
				lpwr_pkg::REG_GAP_MIN:       cfg_q.gap_min       <= cfg_data;
				lpwr_pkg::REG_GAP_MAX:       cfg_q.gap_max       <= cfg_data;
				lpwr_pkg::REG_LATCH_MIN:     cfg_q.latch_min     <= cfg_data;
				lpwr_pkg::REG_STRIP_BYTES:
					cfg_q.strip_bytes <= cfg_data[lpwr_pkg::STRIP_W-1:0];
				default: ;
			endcase
		end
	end

	// Front: classify each edge word and advance the bit/byte state.
	lpwr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.edge_time(s_tdata),
		.pin_level(s_tuser),
		.cfg      (cfg_q),
		.q_full   (q_full),
		.push     (push),
		.push_op  (push_op)
	);

	// Queue: decouple the front from store access and output stalls.
	lpwr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.full   (q_full),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty)
	);

	// Back: read the old pixel byte, update the changed flag, drive results.
	lpwr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_index  (out_index),
		.out_value  (out_value),
		.out_stored (out_stored),
		.out_changed(out_changed)
	);

	// Pack the result word, first field lowest.
	assign m_tdata = {{lpwr_pkg::OUT_PAD_W{1'b0}}, out_changed, out_stored, out_value, out_index};
	assign m_tuser = out_kind;

endmodule
